>>> rtl/hbmt_pkg.sv
// ---------------------------------------------------------------------------
// hbmt_pkg: shared types and constants for the handheld bus map and timer
// Memory sizes, IO register addresses, command and cartridge
// request codes, and the timer period table.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package hbmt_pkg;

  // Clock and memory sizes
  localparam int CPU_CLOCK   = 4194304;
  localparam int VRAM_DEPTH  = 8192;
  localparam int WRAM_DEPTH  = 8192;
  localparam int HRAM_DEPTH  = 127;
  localparam int VRAM_AW     = $clog2(VRAM_DEPTH);
  localparam int WRAM_AW     = $clog2(WRAM_DEPTH);
  localparam int HRAM_AW     = $clog2(HRAM_DEPTH);

  // Timer: tick step size and TIMA periods for each TAC rate select
  localparam int TICK_CLOCKS = 4;
  localparam int PERIOD_0    = CPU_CLOCK / 4096;
  localparam int PERIOD_1    = CPU_CLOCK / 262144;
  localparam int PERIOD_2    = CPU_CLOCK / 65536;
  localparam int PERIOD_3    = CPU_CLOCK / 16384;
  localparam int PERIOD_MAX  = PERIOD_0;
  // Accumulator never exceeds PERIOD_MAX + 3 before a tick adds TICK_CLOCKS
  localparam int ACC_W       = $clog2(PERIOD_MAX + 2 * TICK_CLOCKS);

  // IO register addresses
  localparam logic [15:0] ADDR_JOYP = 16'hFF00;
  localparam logic [15:0] ADDR_SB   = 16'hFF01;
  localparam logic [15:0] ADDR_SC   = 16'hFF02;
  localparam logic [15:0] ADDR_DIV  = 16'hFF04;
  localparam logic [15:0] ADDR_TIMA = 16'hFF05;
  localparam logic [15:0] ADDR_TMA  = 16'hFF06;
  localparam logic [15:0] ADDR_TAC  = 16'hFF07;
  localparam logic [15:0] ADDR_IF   = 16'hFF0F;
  localparam logic [15:0] ADDR_LY   = 16'hFF44;

  // Fixed read values and bit masks
  localparam logic [7:0] LY_VALUE    = 8'h90;
  localparam logic [7:0] OPEN_BUS    = 8'hFF;
  localparam logic [7:0] JOYP_IDLE   = 8'h3F;
  localparam logic [3:0] JOYP_LOW    = 4'hF;
  localparam logic [7:0] SC_START    = 8'h81;
  localparam logic [4:0] IRQ_TIMER   = 5'h04;

  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_TICK  = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    CART_NONE      = 3'd0,
    CART_ROM_READ  = 3'd1,
    CART_ROM_WRITE = 3'd2,
    CART_RAM_READ  = 3'd3,
    CART_RAM_WRITE = 3'd4
  } cart_op_t;

  typedef enum logic [2:0] {
    RGN_ROM,
    RGN_VRAM,
    RGN_CRAM,
    RGN_WRAM,
    RGN_OAM,
    RGN_IO,
    RGN_HRAM,
    RGN_IE
  } region_t;

  // Where the result byte comes from
  typedef enum logic [1:0] {
    RD_LOGIC,
    RD_VRAM,
    RD_WRAM,
    RD_HRAM
  } rd_src_t;

  function automatic logic [ACC_W-1:0] timer_period(input logic [1:0] sel);
    case (sel)
      2'd0:    return ACC_W'(PERIOD_0);
      2'd1:    return ACC_W'(PERIOD_1);
      2'd2:    return ACC_W'(PERIOD_2);
      default: return ACC_W'(PERIOD_3);
    endcase
  endfunction

endpackage

>>> rtl/handheld_bus_map_with_timer_unit.sv
// ---------------------------------------------------------------------------
// handheld_bus_map_with_timer_unit: console memory bus with divider and timer
// Decodes CPU reads, writes and timer ticks against the 16-bit map:
// video, work and high RAM, IO registers, IE, and cartridge forwarding.
// ---------------------------------------------------------------------------
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+------------------------------------------
//  in      | in_valid  | in_stall  | command, address, write_data
//  out     | out_valid | out_stall | read_data, cart_op, cart_address,
//          |           |           | cart_wdata, serial_valid, serial_byte,
//          |           |           | interrupt_flags
//
//  One transaction per cycle sustained while the output is not stalled; a
//  transaction passes through the input register, then the result register.
//  RAM reads use the registered read port of each array, taken at the same
//  edge that loads the result register.
//  Reset (rst, synchronous) clears control and IO registers; RAM contents
//  are not cleared and there is no clearing pass.
//  While the result is stalled one more transaction waits in the input
//  register; the input stalls only when both registers are full.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module handheld_bus_map_with_timer_unit
  import hbmt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  command,
  input  logic [15:0] address,
  input  logic [7:0]  write_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  read_data,
  output logic [2:0]  cart_op,
  output logic [15:0] cart_address,
  output logic [7:0]  cart_wdata,
  output logic        serial_valid,
  output logic [7:0]  serial_byte,
  output logic [4:0]  interrupt_flags
);

  // Input register
  logic        a_valid;
  logic [1:0]  a_cmd;
  logic [15:0] a_addr;
  logic [7:0]  a_data;
  logic        accept;
  logic        move;

  // IO and timer state
  logic [1:0]       joyp_sel,  joyp_sel_next;
  logic [7:0]       sb,        sb_next;
  logic [1:0]       sc,        sc_next;      // {bit 7, bit 0}
  logic [15:0]      div,       div_next;
  logic [ACC_W-1:0] acc,       acc_next;
  logic [7:0]       tima,      tima_next;
  logic [7:0]       tma,       tma_next;
  logic [2:0]       tac,       tac_next;
  logic [4:0]       irq_flags, irq_flags_next;
  logic [4:0]       irq_en,    irq_en_next;

  // Result register
  logic        out_valid_next;
  rd_src_t     b_src,   b_src_next;
  logic [7:0]  b_rdata, b_rdata_next;
  cart_op_t    b_cop,   b_cop_next;
  logic [15:0] b_caddr, b_caddr_next;
  logic [7:0]  b_cwd,   b_cwd_next;
  logic        b_sval,  b_sval_next;
  logic [7:0]  b_sbyte, b_sbyte_next;

  // Memories
  logic [7:0] vram [VRAM_DEPTH];
  logic [7:0] wram [WRAM_DEPTH];
  logic [7:0] hram [HRAM_DEPTH];
  logic [7:0] vram_q, wram_q, hram_q;

  region_t          region;
  cmd_t             cmd;
  logic             is_read, is_write;
  logic [ACC_W-1:0] acc_sum;
  logic [ACC_W-1:0] period;
  logic [7:0]       tima_inc;

  // Handshake: move the held transaction into the result register
  assign move     = a_valid && (!out_valid || !out_stall);
  assign in_stall = a_valid && !move;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (accept) begin
      a_valid <= 1'b1;
    end else if (move) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_cmd  <= command;
      a_addr <= address;
      a_data <= write_data;
    end
  end

  // Address decode
  always_comb begin
    case (a_addr) inside
      [16'h0000:16'h7FFF]: region = RGN_ROM;
      [16'h8000:16'h9FFF]: region = RGN_VRAM;
      [16'hA000:16'hBFFF]: region = RGN_CRAM;
      [16'hC000:16'hFDFF]: region = RGN_WRAM;
      [16'hFE00:16'hFEFF]: region = RGN_OAM;
      [16'hFF00:16'hFF7F]: region = RGN_IO;
      [16'hFF80:16'hFFFE]: region = RGN_HRAM;
      default:             region = RGN_IE;
    endcase
  end

  assign cmd      = cmd_t'(a_cmd);
  assign is_read  = (cmd == CMD_READ);
  assign is_write = (cmd == CMD_WRITE);

  // Timer arithmetic
  assign period   = timer_period(tac[1:0]);
  assign acc_sum  = acc + ACC_W'(TICK_CLOCKS);
  assign tima_inc = tima + 8'd1;

  // Next state and result fields
  always_comb begin
    joyp_sel_next  = joyp_sel;
    sb_next        = sb;
    sc_next        = sc;
    div_next       = div;
    acc_next       = acc;
    tima_next      = tima;
    tma_next       = tma;
    tac_next       = tac;
    irq_flags_next = irq_flags;
    irq_en_next    = irq_en;
    b_src_next     = RD_LOGIC;
    b_rdata_next   = 8'h00;
    b_cop_next     = CART_NONE;
    b_caddr_next   = 16'h0000;
    b_cwd_next     = 8'h00;
    b_sval_next    = 1'b0;
    b_sbyte_next   = 8'h00;

    case (cmd)
      CMD_READ: begin
        case (region)
          RGN_ROM: begin
            b_rdata_next = OPEN_BUS;
            b_cop_next   = CART_ROM_READ;
            b_caddr_next = a_addr;
          end
          RGN_CRAM: begin
            b_rdata_next = OPEN_BUS;
            b_cop_next   = CART_RAM_READ;
            b_caddr_next = a_addr;
          end
          RGN_VRAM: b_src_next = RD_VRAM;
          RGN_WRAM: b_src_next = RD_WRAM;
          RGN_HRAM: b_src_next = RD_HRAM;
          RGN_IE:   b_rdata_next = {3'b000, irq_en};
          RGN_IO: begin
            case (a_addr)
              ADDR_JOYP: b_rdata_next = (joyp_sel != 2'd0) ?
                                        {2'b00, joyp_sel, JOYP_LOW} : JOYP_IDLE;
              ADDR_SB:   b_rdata_next = sb;
              ADDR_SC:   b_rdata_next = {sc[1], 6'b000000, sc[0]};
              ADDR_DIV:  b_rdata_next = div[15:8];
              ADDR_TIMA: b_rdata_next = tima;
              ADDR_TMA:  b_rdata_next = tma;
              ADDR_TAC:  b_rdata_next = {5'b00000, tac};
              ADDR_IF:   b_rdata_next = {3'b000, irq_flags};
              ADDR_LY:   b_rdata_next = LY_VALUE;
              default:   b_rdata_next = OPEN_BUS;
            endcase
          end
          default: b_rdata_next = OPEN_BUS;
        endcase
      end

      CMD_WRITE: begin
        case (region)
          RGN_ROM: begin
            b_cop_next   = CART_ROM_WRITE;
            b_caddr_next = a_addr;
            b_cwd_next   = a_data;
          end
          RGN_CRAM: begin
            b_cop_next   = CART_RAM_WRITE;
            b_caddr_next = a_addr;
            b_cwd_next   = a_data;
          end
          RGN_IE: irq_en_next = a_data[4:0];
          RGN_IO: begin
            case (a_addr)
              ADDR_JOYP: joyp_sel_next = a_data[5:4];
              ADDR_SB:   sb_next = a_data;
              ADDR_SC: begin
                sc_next = {a_data[7], a_data[0]};
                // transfer start emits the current serial data byte
                if ((a_data & SC_START) == SC_START) begin
                  b_sval_next  = 1'b1;
                  b_sbyte_next = sb;
                end
              end
              ADDR_DIV:  div_next = 16'h0000;
              ADDR_TIMA: tima_next = a_data;
              ADDR_TMA:  tma_next = a_data;
              ADDR_TAC:  tac_next = a_data[2:0];
              ADDR_IF:   irq_flags_next = a_data[4:0];
              default:   ;
            endcase
          end
          default: ;  // RAM writes go to the arrays, OAM/unused ignored
        endcase
      end

      CMD_TICK: begin
        div_next = div + 16'(TICK_CLOCKS);
        if (tac[2]) begin
          acc_next = acc_sum;
          // at most one period drained per tick
          if (acc_sum >= period) begin
            acc_next = acc_sum - period;
            if (tima_inc == 8'h00) begin
              tima_next      = tma;
              irq_flags_next = irq_flags | IRQ_TIMER;
            end else begin
              tima_next = tima_inc;
            end
          end
        end
      end

      default: ;
    endcase
  end

  // IO and timer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      joyp_sel  <= 2'd3;
      sb        <= 8'h00;
      sc        <= 2'b00;
      div       <= 16'h0000;
      acc       <= '0;
      tima      <= 8'h00;
      tma       <= 8'h00;
      tac       <= 3'b000;
      irq_flags <= 5'h00;
      irq_en    <= 5'h00;
    end else if (move) begin
      joyp_sel  <= joyp_sel_next;
      sb        <= sb_next;
      sc        <= sc_next;
      div       <= div_next;
      acc       <= acc_next;
      tima      <= tima_next;
      tma       <= tma_next;
      tac       <= tac_next;
      irq_flags <= irq_flags_next;
      irq_en    <= irq_en_next;
    end
  end

  // Video RAM
  always_ff @(posedge clk) begin
    if (move && is_write && region == RGN_VRAM) begin
      vram[a_addr[VRAM_AW-1:0]] <= a_data;
    end
    if (move && is_read && region == RGN_VRAM) begin
      vram_q <= vram[a_addr[VRAM_AW-1:0]];
    end
  end

  // Work RAM; the echo region maps onto the same low address bits
  always_ff @(posedge clk) begin
    if (move && is_write && region == RGN_WRAM) begin
      wram[a_addr[WRAM_AW-1:0]] <= a_data;
    end
    if (move && is_read && region == RGN_WRAM) begin
      wram_q <= wram[a_addr[WRAM_AW-1:0]];
    end
  end

  // High RAM
  always_ff @(posedge clk) begin
    if (move && is_write && region == RGN_HRAM) begin
      hram[a_addr[HRAM_AW-1:0]] <= a_data;
    end
    if (move && is_read && region == RGN_HRAM) begin
      hram_q <= hram[a_addr[HRAM_AW-1:0]];
    end
  end

  // Result register
  always_comb begin
    if (move) begin
      out_valid_next = 1'b1;
    end else if (out_valid && out_stall) begin
      out_valid_next = 1'b1;
    end else begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      b_src   <= b_src_next;
      b_rdata <= b_rdata_next;
      b_cop   <= b_cop_next;
      b_caddr <= b_caddr_next;
      b_cwd   <= b_cwd_next;
      b_sval  <= b_sval_next;
      b_sbyte <= b_sbyte_next;
    end
  end

  // Outputs
  always_comb begin
    case (b_src)
      RD_VRAM: read_data = vram_q;
      RD_WRAM: read_data = wram_q;
      RD_HRAM: read_data = hram_q;
      default: read_data = b_rdata;
    endcase
  end

  assign cart_op      = b_cop;
  assign cart_address = b_caddr;
  assign cart_wdata   = b_cwd;
  assign serial_valid = b_sval;
  assign serial_byte  = b_sbyte;
  // IF updates on the same edge that loads the result, so it is the
  // post-transaction value for the transaction on the output
  assign interrupt_flags = irq_flags;

`ifndef SYNTHESIS
  // Accumulator stays in range of its width
  a_acc_bound: assert property (@(posedge clk) disable iff (rst)
    acc <= ACC_W'(PERIOD_MAX + TICK_CLOCKS - 1))
    else $error("timer accumulator out of range");

  // A serial start never coincides with a cartridge request
  a_serial_no_cart: assert property (@(posedge clk) disable iff (rst)
    out_valid && serial_valid |-> cart_op == CART_NONE)
    else $error("serial start with cartridge request");

  // ROM requests carry a ROM address
  a_rom_addr: assert property (@(posedge clk) disable iff (rst)
    out_valid && (cart_op == CART_ROM_READ || cart_op == CART_ROM_WRITE)
    |-> !cart_address[15])
    else $error("ROM request outside ROM space");

  // A stalled input transaction stays in the input register
  a_hold_input: assert property (@(posedge clk) disable iff (rst)
    a_valid && !move |=> a_valid && $stable(a_addr) && $stable(a_cmd))
    else $error("held transaction lost");

  // With the timer off a tick leaves TIMA alone
  a_timer_off: assert property (@(posedge clk) disable iff (rst)
    move && cmd == CMD_TICK && !tac[2] |=> $stable(tima))
    else $error("TIMA changed with timer disabled");
`endif

endmodule
